/* sv/buffer_cache_lru_policy_macros.svh */
`ifndef BUFFER_CACHE_LRU_POLICY_MACROS_SVH
`define BUFFER_CACHE_LRU_POLICY_MACROS_SVH

// Implication checked in the same cycle.
`define BCLP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle.
`define BCLP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/bclp_pkg.sv */
package bclp_pkg;

	localparam int unsigned DefNumBuffers = 16;
	localparam int unsigned DefBlockBits  = 32;

	localparam logic [1:0] CMD_ACQUIRE = 2'd0;
	localparam logic [1:0] CMD_READ    = 2'd1;
	localparam logic [1:0] CMD_WRITE   = 2'd2;
	localparam logic [1:0] CMD_RELEASE = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_CLEAN   = 3'd1;
	localparam logic [2:0] ST_DIRTY   = 3'd2;
	localparam logic [2:0] ST_NOFREE  = 3'd3;
	localparam logic [2:0] ST_UNDER   = 3'd4;

	localparam logic [7:0] REF_MAX = 8'hFF;

	// Control that the sequencer broadcasts to every cell of the ring.
	typedef struct packed {
		logic shift;
		logic upd;
		logic mru;
	} cell_ctl_t;

endpackage

/* sv/buffer_cache_lru_policy.sv */
// Channel   Handshake        Ports
// request   start / busy     command, device, block_number, entry
// result    done (strobe)    slot, status, disk_read, disk_write, write_device,
//                            write_block, references
//
// The ring of cells rotates once past its last cell so the sequencer sees every
// entry in recency order, then the apply state applies the update.
// busy is high from the accept until the cycle the result is shown.
// Reset puts slot i at recency position i with all tags and counts cleared.
// The done strobe is high for one cycle only; the receiver cannot stall it.
module buffer_cache_lru_policy import bclp_pkg::*; #(
	parameter int unsigned NUM_BUFFERS = DefNumBuffers,
	parameter int unsigned BLOCK_BITS  = DefBlockBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [3:0]  device,
	input  logic [31:0] block_number,
	input  logic [3:0]  entry,
	output logic        done,
	output logic [3:0]  slot,
	output logic [2:0]  status,
	output logic        disk_read,
	output logic        disk_write,
	output logic [3:0]  write_device,
	output logic [31:0] write_block,
	output logic [7:0]  references
);

	`include "buffer_cache_lru_policy_macros.svh"

	localparam int unsigned SW = $clog2(NUM_BUFFERS);
	localparam int unsigned N  = NUM_BUFFERS;

	typedef enum logic [1:0] {IDLE, SCAN, APPLY} state_t;
	state_t state_q;

	logic [SW-1:0]         cnt_q;
	logic [1:0]            cmd_q;
	logic [3:0]            dev_q;
	logic [BLOCK_BITS-1:0] blk_q;
	logic [3:0]            ent_q;

	logic                  hit_q, clean_q, dfnd_q;
	logic [SW-1:0]         hit_slot_q, clean_slot_q, dslot_q, ent_pos_q;
	logic [7:0]            hit_ref_q, ent_ref_q;
	logic                  hit_val_q, hit_dirty_q, ent_val_q;
	logic [3:0]            ddev_q, ent_dev_q;
	logic [BLOCK_BITS-1:0] dblk_q, ent_blk_q;
	logic                  ent_dirty_q;

	logic [SW-1:0]         c_slot  [N];
	logic [3:0]            c_dev   [N];
	logic [BLOCK_BITS-1:0] c_blk   [N];
	logic [7:0]            c_ref   [N];
	logic                  c_val   [N];
	logic                  c_dirty [N];

	cell_ctl_t             ctl;
	logic [SW-1:0]         tgt;
	logic [3:0]            n_dev;
	logic [BLOCK_BITS-1:0] n_blk;
	logic [7:0]            n_ref;
	logic                  n_val, n_dirty;
	logic [3:0]            o_slot;
	logic [2:0]            o_st;
	logic                  o_rd, o_wr;
	logic [3:0]            o_wdev;
	logic [31:0]           o_wblk;
	logic [7:0]            o_ref;
	logic                  ent_oob, tail_ent;

	for (genvar p = 0; p < N; p++) begin : g_cell
		localparam int unsigned PP = (p == 0) ? N - 1 : p - 1;
		bclp_cell #(
			.NUM_BUFFERS(NUM_BUFFERS),
			.BLOCK_BITS (BLOCK_BITS),
			.POS        (p)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.tgt_slot  (tgt),
			.mru_pos   (ent_pos_q),
			.prev_slot (c_slot[PP]),
			.prev_dev  (c_dev[PP]),
			.prev_blk  (c_blk[PP]),
			.prev_ref  (c_ref[PP]),
			.prev_val  (c_val[PP]),
			.prev_dirty(c_dirty[PP]),
			.new_dev   (n_dev),
			.new_blk   (n_blk),
			.new_ref   (n_ref),
			.new_val   (n_val),
			.new_dirty (n_dirty),
			.slot_q    (c_slot[p]),
			.dev_q     (c_dev[p]),
			.blk_q     (c_blk[p]),
			.ref_q     (c_ref[p]),
			.val_q     (c_val[p]),
			.dirty_q   (c_dirty[p])
		);
	end

	assign busy     = (state_q != IDLE);
	assign ent_oob  = 32'(ent_q) >= 32'(N);
	assign tail_ent = (32'(c_slot[N-1]) == 32'(ent_q));

	// Decision for the item, taken in the apply cycle from what the scan gathered.
	always_comb begin
		ctl      = '0;
		ctl.shift = (state_q == SCAN);
		tgt      = '0;
		n_dev    = dev_q;
		n_blk    = blk_q;
		n_ref    = '0;
		n_val    = 1'b0;
		n_dirty  = 1'b0;
		o_slot   = ent_q;
		o_st     = ST_OK;
		o_rd     = 1'b0;
		o_wr     = 1'b0;
		o_wdev   = '0;
		o_wblk   = '0;
		o_ref    = '0;
		case (cmd_q)
			CMD_ACQUIRE, CMD_READ: begin
				ctl.upd = 1'b1;
				if (hit_q) begin
					tgt     = hit_slot_q;
					n_ref   = (hit_ref_q == REF_MAX) ? REF_MAX : hit_ref_q + 8'd1;
					n_val   = hit_val_q;
					n_dirty = hit_dirty_q;
				end else if (clean_q) begin
					tgt   = clean_slot_q;
					n_ref = 8'd1;
					o_st  = ST_CLEAN;
				end else if (dfnd_q) begin
					tgt    = dslot_q;
					n_ref  = 8'd1;
					o_st   = ST_DIRTY;
					o_wr   = 1'b1;
					o_wdev = ddev_q;
					o_wblk = 32'(dblk_q);
				end else begin
					ctl.upd = 1'b0;
					o_st    = ST_NOFREE;
				end
				if (ctl.upd) begin
					if (cmd_q == CMD_READ && !n_val) begin
						o_rd  = 1'b1;
						n_val = 1'b1;
					end
					o_slot = 4'(tgt);
					o_ref  = n_ref;
				end else begin
					o_slot = '0;
				end
			end
			CMD_WRITE: begin
				tgt     = SW'(ent_q);
				n_dev   = ent_dev_q;
				n_blk   = ent_blk_q;
				n_ref   = ent_ref_q;
				n_val   = ent_val_q;
				n_dirty = 1'b1;
				if (ent_oob) begin
					o_st = ST_NOFREE;
				end else begin
					ctl.upd = 1'b1;
					o_wr    = 1'b1;
					o_wdev  = ent_dev_q;
					o_wblk  = 32'(ent_blk_q);
					o_ref   = ent_ref_q;
				end
			end
			default: begin
				tgt     = SW'(ent_q);
				n_dev   = ent_dev_q;
				n_blk   = ent_blk_q;
				n_ref   = ent_ref_q - 8'd1;
				n_val   = ent_val_q;
				n_dirty = ent_dirty_q;
				if (ent_oob) begin
					o_st = ST_NOFREE;
				end else if (ent_ref_q == '0) begin
					o_st = ST_UNDER;
				end else begin
					ctl.upd = 1'b1;
					ctl.mru = (n_ref == '0);
					o_ref   = n_ref;
				end
			end
		endcase
		if (state_q != APPLY) begin
			ctl.upd = 1'b0;
			ctl.mru = 1'b0;
		end
	end

	// The dirty mark of the released entry must survive the update.
	always_ff @(posedge clk) begin
		if (state_q == SCAN && tail_ent) begin
			ent_dirty_q <= c_dirty[N-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
			done    <= 1'b0;
			hit_q   <= 1'b0;
			clean_q <= 1'b0;
			dfnd_q  <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				IDLE: begin
					if (start) begin
						state_q <= SCAN;
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						clean_q <= 1'b0;
						dfnd_q  <= 1'b0;
					end
				end
				SCAN: begin
					// The last cell sees the entries from least to most recent.
					if (c_dev[N-1] == dev_q && c_blk[N-1] == blk_q) begin
						hit_q <= 1'b1;
					end
					if (c_ref[N-1] == '0 && !c_dirty[N-1]) begin
						clean_q <= 1'b1;
					end
					if (c_ref[N-1] == '0 && c_dirty[N-1]) begin
						dfnd_q <= 1'b1;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SW'(N - 1)) begin
						state_q <= APPLY;
					end
				end
				APPLY: begin
					state_q <= IDLE;
					done    <= 1'b1;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE && start) begin
			cmd_q <= command;
			dev_q <= device;
			blk_q <= BLOCK_BITS'(block_number);
			ent_q <= entry;
		end
		if (state_q == SCAN) begin
			if (c_dev[N-1] == dev_q && c_blk[N-1] == blk_q) begin
				hit_slot_q  <= c_slot[N-1];
				hit_ref_q   <= c_ref[N-1];
				hit_val_q   <= c_val[N-1];
				hit_dirty_q <= c_dirty[N-1];
			end
			if (!clean_q && c_ref[N-1] == '0 && !c_dirty[N-1]) begin
				clean_slot_q <= c_slot[N-1];
			end
			if (!dfnd_q && c_ref[N-1] == '0 && c_dirty[N-1]) begin
				dslot_q <= c_slot[N-1];
				ddev_q  <= c_dev[N-1];
				dblk_q  <= c_blk[N-1];
			end
			if (tail_ent) begin
				ent_pos_q <= SW'(N - 1) - cnt_q;
				ent_ref_q <= c_ref[N-1];
				ent_val_q <= c_val[N-1];
				ent_dev_q <= c_dev[N-1];
				ent_blk_q <= c_blk[N-1];
			end
		end
		if (state_q == APPLY) begin
			slot         <= o_slot;
			status       <= o_st;
			disk_read    <= o_rd;
			disk_write   <= o_wr;
			write_device <= o_wdev;
			write_block  <= o_wblk;
			references   <= o_ref;
		end
	end

	`BCLP_ASSERT_NXT(a_busy_after_start, start && !busy, busy, "busy missing after accept")
	`BCLP_ASSERT_IMP(a_done_not_busy, done, !busy, "result shown while busy")
	`BCLP_ASSERT_IMP(a_nofree_quiet, done && status == ST_NOFREE, !disk_read && !disk_write,
		"disk request on failed item")

endmodule

/* sv/bclp_cell.sv */
module bclp_cell import bclp_pkg::*; #(
	parameter int unsigned NUM_BUFFERS = DefNumBuffers,
	parameter int unsigned BLOCK_BITS  = DefBlockBits,
	parameter int unsigned POS         = 0,
	localparam int unsigned SW = $clog2(NUM_BUFFERS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctl_t             ctl,
	input  logic [SW-1:0]         tgt_slot,
	input  logic [SW-1:0]         mru_pos,
	input  logic [SW-1:0]         prev_slot,
	input  logic [3:0]            prev_dev,
	input  logic [BLOCK_BITS-1:0] prev_blk,
	input  logic [7:0]            prev_ref,
	input  logic                  prev_val,
	input  logic                  prev_dirty,
	input  logic [3:0]            new_dev,
	input  logic [BLOCK_BITS-1:0] new_blk,
	input  logic [7:0]            new_ref,
	input  logic                  new_val,
	input  logic                  new_dirty,
	output logic [SW-1:0]         slot_q,
	output logic [3:0]            dev_q,
	output logic [BLOCK_BITS-1:0] blk_q,
	output logic [7:0]            ref_q,
	output logic                  val_q,
	output logic                  dirty_q
);

	logic in_move;

	// Cells at or below the released slot's position slide one place back.
	assign in_move = ctl.mru && (SW'(POS) <= mru_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= SW'(POS);
			dev_q   <= '0;
			blk_q   <= '0;
			ref_q   <= '0;
			val_q   <= 1'b0;
			dirty_q <= 1'b0;
		end else if (ctl.shift || (in_move && POS != 0)) begin
			slot_q  <= prev_slot;
			dev_q   <= prev_dev;
			blk_q   <= prev_blk;
			ref_q   <= prev_ref;
			val_q   <= prev_val;
			dirty_q <= prev_dirty;
		end else if ((in_move && POS == 0) || (ctl.upd && slot_q == tgt_slot)) begin
			slot_q  <= tgt_slot;
			dev_q   <= new_dev;
			blk_q   <= new_blk;
			ref_q   <= new_ref;
			val_q   <= new_val;
			dirty_q <= new_dirty;
		end
	end

endmodule
